// ----- sv/vfv_pkg.sv -----
package vfv_pkg;

   localparam int CHUNK_WIDTH  = 16;
   localparam int CHUNK_HEIGHT = 64;
   localparam int VOXEL_COUNT  = CHUNK_WIDTH * CHUNK_HEIGHT * CHUNK_WIDTH;
   localparam int ADDR_W       = $clog2(VOXEL_COUNT);

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef logic [2:0] kind_type;
   typedef logic [2:0] tile_type;

   localparam kind_type KIND_AIR    = 3'd0;
   localparam kind_type KIND_GRASS  = 3'd1;
   localparam kind_type KIND_DIRT   = 3'd2;
   localparam kind_type KIND_STONE  = 3'd3;
   localparam kind_type KIND_SAND   = 3'd4;
   localparam kind_type KIND_WOOD   = 3'd5;
   localparam kind_type KIND_LEAVES = 3'd6;
   localparam kind_type KIND_OTHER  = 3'd7;

   function automatic tile_type top_tile_of(input kind_type kind);
      tile_type t;
      case (kind)
         KIND_GRASS:  t = 3'd0;
         KIND_DIRT:   t = 3'd2;
         KIND_STONE:  t = 3'd3;
         KIND_SAND:   t = 3'd7;
         KIND_WOOD:   t = 3'd5;
         KIND_LEAVES: t = 3'd6;
         default:     t = 3'd0;
      endcase
      return t;
   endfunction

   function automatic tile_type side_tile_of(input kind_type kind);
      tile_type t;
      case (kind)
         KIND_GRASS:  t = 3'd1;
         KIND_DIRT:   t = 3'd2;
         KIND_STONE:  t = 3'd3;
         KIND_SAND:   t = 3'd7;
         KIND_WOOD:   t = 3'd4;
         KIND_LEAVES: t = 3'd6;
         default:     t = 3'd0;
      endcase
      return t;
   endfunction

   // linear address: (x * height + y) * width + z
   function automatic logic [ADDR_W-1:0] cell_index(input logic [4:0] x,
                                                    input logic [6:0] y,
                                                    input logic [4:0] z);
      int lin;
      lin = (int'(x) * CHUNK_HEIGHT + int'(y)) * CHUNK_WIDTH + int'(z);
      return lin[ADDR_W-1:0];
   endfunction

endpackage

// ----- sv/voxel_face_visibility.sv -----
// Voxel face visibility for one chunk of block types.
// Input channel (req_*): cmd selects a write of req_block_kind at the given
// position, which gives no result, or a query of that position, which gives
// one result beat on the rsp_* channel: the mask of exposed faces, the top and
// side atlas tiles, and a flag for a solid block without a tile.
// A write is done in ST_IDLE; the block stays ready for the next request.
// A query reads the single-port voxel memory seven times (centre and six
// neighbours, one read a cycle, registered read data) in ST_QUERY, then
// passes ST_DRAIN and ST_DONE, where the result register is loaded once
// rsp_* is free. The block takes no new request while a query is in flight;
// req_ready rises again together with rsp_valid when the result is loaded.
// A result waiting on rsp_ready does not block new requests; a query that
// finishes while the previous result still waits holds until it is taken.
// After reset the block sweeps the whole memory to air, one voxel a cycle,
// with req_ready low for that time.
module voxel_face_visibility
   import vfv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_cmd,
   input  logic [3:0] req_pos_x,
   input  logic [5:0] req_pos_y,
   input  logic [3:0] req_pos_z,
   input  logic [2:0] req_block_kind,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [5:0] rsp_face_mask,
   output logic [2:0] rsp_top_tile,
   output logic [2:0] rsp_side_tile,
   output logic       rsp_bad_block
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_QUERY,
      ST_DRAIN,
      ST_DONE
   } state_type;

   localparam logic [2:0] STEP_CENTRE = 3'd0;
   localparam logic [2:0] STEP_YP     = 3'd1;
   localparam logic [2:0] STEP_YN     = 3'd2;
   localparam logic [2:0] STEP_XN     = 3'd3;
   localparam logic [2:0] STEP_XP     = 3'd4;
   localparam logic [2:0] STEP_ZN     = 3'd5;
   localparam logic [2:0] STEP_ZP     = 3'd6;

   state_type         state_ff;
   logic [ADDR_W-1:0] clr_cnt_ff;
   logic [2:0]        step_ff;
   logic [3:0]        qx_ff;
   logic [5:0]        qy_ff;
   logic [3:0]        qz_ff;
   logic              probe_vld_ff;
   logic              probe_in_ff;
   logic [2:0]        probe_step_ff;
   kind_type          centre_ff;
   logic [5:0]        mask_ff;
   logic              rsp_valid_ff;
   logic [5:0]        rsp_face_mask_ff;
   tile_type          rsp_top_tile_ff;
   tile_type          rsp_side_tile_ff;
   logic              rsp_bad_block_ff;

   kind_type          voxel_mem [VOXEL_COUNT];
   kind_type          mem_rd_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_addr;
   kind_type          mem_wdata;

   logic [4:0]        nx;
   logic [6:0]        ny;
   logic [4:0]        nz;
   logic              below;
   logic              probe_inside;
   logic [ADDR_W-1:0] probe_addr;
   logic              req_inside;
   logic              accept;
   logic              rsp_free;
   logic              rsp_load;
   logic [2:0]        bit_sel;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_load  = (state_ff == ST_DONE) && rsp_free;
   assign bit_sel   = probe_step_ff - 3'd1;

   assign req_inside = (int'(req_pos_x) < CHUNK_WIDTH) && (int'(req_pos_y) < CHUNK_HEIGHT)
                       && (int'(req_pos_z) < CHUNK_WIDTH);

   // neighbour coordinate for the current probe step
   always_comb begin
      nx    = {1'b0, qx_ff};
      ny    = {1'b0, qy_ff};
      nz    = {1'b0, qz_ff};
      below = 1'b0;
      case (step_ff)
         STEP_YP: ny = ny + 7'd1;
         STEP_YN: begin
            below = (qy_ff == 6'd0);
            ny    = ny - 7'd1;
         end
         STEP_XN: begin
            below = (qx_ff == 4'd0);
            nx    = nx - 5'd1;
         end
         STEP_XP: nx = nx + 5'd1;
         STEP_ZN: begin
            below = (qz_ff == 4'd0);
            nz    = nz - 5'd1;
         end
         STEP_ZP: nz = nz + 5'd1;
         default: ;
      endcase
      probe_inside = !below && (int'(nx) < CHUNK_WIDTH) && (int'(ny) < CHUNK_HEIGHT)
                     && (int'(nz) < CHUNK_WIDTH);
      probe_addr   = cell_index(nx, ny, nz);
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_wdata = KIND_AIR;
      mem_addr  = probe_addr;
      case (state_ff)
         ST_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = clr_cnt_ff;
         end
         ST_IDLE: begin
            mem_we    = accept && (req_cmd == CMD_WRITE) && req_inside;
            mem_wdata = req_block_kind;
            mem_addr  = cell_index({1'b0, req_pos_x}, {1'b0, req_pos_y}, {1'b0, req_pos_z});
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         voxel_mem[mem_addr] <= mem_wdata;
      end
      mem_rd_ff <= voxel_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         step_ff      <= STEP_CENTRE;
         probe_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         probe_vld_ff  <= (state_ff == ST_QUERY);
         probe_in_ff   <= probe_inside;
         probe_step_ff <= step_ff;

         // fold the returning read into centre kind or mask bit
         if (probe_vld_ff) begin
            if (probe_step_ff == STEP_CENTRE) begin
               centre_ff <= probe_in_ff ? mem_rd_ff : KIND_AIR;
            end else begin
               mask_ff[bit_sel] <= !(probe_in_ff && (mem_rd_ff != KIND_AIR));
            end
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == ADDR_W'(VOXEL_COUNT - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept && (req_cmd == CMD_QUERY)) begin
                  qx_ff    <= req_pos_x;
                  qy_ff    <= req_pos_y;
                  qz_ff    <= req_pos_z;
                  step_ff  <= STEP_CENTRE;
                  state_ff <= ST_QUERY;
               end
            end
            ST_QUERY: begin
               step_ff <= step_ff + 3'd1;
               if (step_ff == STEP_ZP) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               // hold until the previous result beat is taken
               if (rsp_free) begin
                  if (centre_ff == KIND_AIR) begin
                     rsp_face_mask_ff <= '0;
                  end else begin
                     rsp_face_mask_ff <= mask_ff;
                  end
                  rsp_top_tile_ff  <= top_tile_of(centre_ff);
                  rsp_side_tile_ff <= side_tile_of(centre_ff);
                  rsp_bad_block_ff <= (centre_ff == KIND_OTHER);
                  state_ff         <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_face_mask = rsp_face_mask_ff;
   assign rsp_top_tile  = rsp_top_tile_ff;
   assign rsp_side_tile = rsp_side_tile_ff;
   assign rsp_bad_block = rsp_bad_block_ff;

`ifndef ASSERT_OFF
   a_no_req_while_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("request taken during memory clear");

   a_write_only_idle: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CLEAR || state_ff == ST_IDLE))
      else $error("memory written during a query");

   a_probe_follows_query: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QUERY) |=> probe_vld_ff)
      else $error("memory read data not folded");

   a_done_loads_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_free) |=> (rsp_valid && state_ff == ST_IDLE))
      else $error("finished query not presented");
`endif

endmodule

// ----- sim/tb_voxel_face_visibility.sv -----
`timescale 1ns / 1ps

module tb_voxel_face_visibility;
   import vfv_pkg::*;

   // face bits of the result mask
   localparam int FACE_POS_Y = 0;
   localparam int FACE_NEG_Y = 1;
   localparam int FACE_NEG_X = 2;
   localparam int FACE_POS_X = 3;
   localparam int FACE_NEG_Z = 4;
   localparam int FACE_POS_Z = 5;
   localparam logic [5:0] ALL_FACES = 6'h3F;

   localparam int RANDOM_ITEMS = 1630;
   localparam int CLUSTER_ITEMS = 48;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 30;

   typedef struct packed {
      logic [5:0] face_mask;
      tile_type   top_tile;
      tile_type   side_tile;
      logic       bad_block;
   } face_report_type;

   typedef struct packed {
      logic            cmd;
      logic [3:0]      x;
      logic [5:0]      y;
      logic [3:0]      z;
      kind_type        kind;
      logic            typed;
      face_report_type report;
   } voxel_op_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_cmd = CMD_WRITE;
   logic [3:0] req_pos_x = '0;
   logic [5:0] req_pos_y = '0;
   logic [3:0] req_pos_z = '0;
   logic [2:0] req_block_kind = KIND_AIR;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [5:0] rsp_face_mask;
   logic [2:0] rsp_top_tile;
   logic [2:0] rsp_side_tile;
   logic       rsp_bad_block;

   kind_type        chunk_model [VOXEL_COUNT];
   face_report_type expected_faces [$];
   voxel_op_type    directed_ops [$];

   int mismatch_count = 0;
   int write_count = 0;
   int query_count = 0;
   int solid_queries = 0;
   int hidden_faces = 0;
   int beats_checked = 0;
   bit calm = 1'b0;

   voxel_face_visibility DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_pos_z      (req_pos_z),
      .req_block_kind (req_block_kind),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_face_mask  (rsp_face_mask),
      .rsp_top_tile   (rsp_top_tile),
      .rsp_side_tile  (rsp_side_tile),
      .rsp_bad_block  (rsp_bad_block)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int voxel_slot(input int x, input int y, input int z);
      return (x * CHUNK_HEIGHT + y) * CHUNK_WIDTH + z;
   endfunction

   // anything outside the chunk counts as air
   function automatic bit solid_cell(input int x, input int y, input int z);
      if (x < 0 || x >= CHUNK_WIDTH || y < 0 || y >= CHUNK_HEIGHT ||
          z < 0 || z >= CHUNK_WIDTH)
         return 1'b0;
      return chunk_model[voxel_slot(x, y, z)] != KIND_AIR;
   endfunction

   function automatic face_report_type predict_faces(input int x, input int y, input int z);
      face_report_type r;
      kind_type centre;
      r = '0;
      centre = chunk_model[voxel_slot(x, y, z)];
      if (centre == KIND_AIR)
         return r;
      r.face_mask[FACE_POS_Y] = !solid_cell(x, y + 1, z);
      r.face_mask[FACE_NEG_Y] = !solid_cell(x, y - 1, z);
      r.face_mask[FACE_NEG_X] = !solid_cell(x - 1, y, z);
      r.face_mask[FACE_POS_X] = !solid_cell(x + 1, y, z);
      r.face_mask[FACE_NEG_Z] = !solid_cell(x, y, z - 1);
      r.face_mask[FACE_POS_Z] = !solid_cell(x, y, z + 1);
      case (centre)
         KIND_GRASS: begin
            r.top_tile = 3'd0;
            r.side_tile = 3'd1;
         end
         KIND_DIRT: begin
            r.top_tile = 3'd2;
            r.side_tile = 3'd2;
         end
         KIND_STONE: begin
            r.top_tile = 3'd3;
            r.side_tile = 3'd3;
         end
         KIND_SAND: begin
            r.top_tile = 3'd7;
            r.side_tile = 3'd7;
         end
         KIND_WOOD: begin
            r.top_tile = 3'd5;
            r.side_tile = 3'd4;
         end
         KIND_LEAVES: begin
            r.top_tile = 3'd6;
            r.side_tile = 3'd6;
         end
         default: r.bad_block = 1'b1;
      endcase
      return r;
   endfunction

   function automatic voxel_op_type op(input logic cmd, input int x, input int y, input int z,
                                       input kind_type kind);
      voxel_op_type v;
      v = '0;
      v.cmd = cmd;
      v.x = 4'(x);
      v.y = 6'(y);
      v.z = 4'(z);
      v.kind = kind;
      return v;
   endfunction

   function automatic voxel_op_type query_typed(input int x, input int y, input int z,
                                                input logic [5:0] mask, input tile_type top,
                                                input tile_type side, input logic bad);
      voxel_op_type v;
      v = op(CMD_QUERY, x, y, z, KIND_AIR);
      v.typed = 1'b1;
      v.report = '{mask, top, side, bad};
      return v;
   endfunction

   // writes build up the cluster first, then queries dominate
   function automatic voxel_op_type random_op(input int bx, input int by, input int bz,
                                              input int phase);
      voxel_op_type v;
      v = '0;
      if (phase < 16)
         v.cmd = ($urandom_range(99) < 20) ? CMD_QUERY : CMD_WRITE;
      else
         v.cmd = ($urandom_range(99) < 60) ? CMD_QUERY : CMD_WRITE;
      if ($urandom_range(99) < 75) begin
         v.x = 4'(bx + $urandom_range(3));
         v.y = 6'(by + $urandom_range(3));
         v.z = 4'(bz + $urandom_range(3));
      end else begin
         v.x = 4'($urandom_range(15));
         v.y = 6'($urandom_range(63));
         v.z = 4'($urandom_range(15));
      end
      v.kind = ($urandom_range(99) < 25) ? KIND_AIR : kind_type'($urandom_range(7, 1));
      return v;
   endfunction

   function automatic void take_beat(input voxel_op_type v);
      face_report_type r;
      kind_type centre;
      if (v.cmd == CMD_WRITE) begin
         chunk_model[voxel_slot(v.x, v.y, v.z)] = v.kind;
         write_count++;
      end else begin
         centre = chunk_model[voxel_slot(v.x, v.y, v.z)];
         r = v.typed ? v.report : predict_faces(v.x, v.y, v.z);
         expected_faces.push_back(r);
         query_count++;
         if (centre != KIND_AIR) begin
            solid_queries++;
            hidden_faces += 6 - $countones(r.face_mask);
         end
      end
   endfunction

   task automatic send_op(input voxel_op_type v);
      while (!calm && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= v.cmd;
      req_pos_x <= v.x;
      req_pos_y <= v.y;
      req_pos_z <= v.z;
      req_block_kind <= v.kind;
      do @(posedge clock); while (!req_ready);
      take_beat(v);
   endtask

   function automatic void check_field(input string name, input int exp, input int act);
      if (exp != act) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp, act);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : check_beat
      face_report_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_faces.size() == 0) begin
            $display("%0t: unexpected result, expected none, got mask %b tiles %0d/%0d bad %b",
                     $time, rsp_face_mask, rsp_top_tile, rsp_side_tile, rsp_bad_block);
            mismatch_count++;
         end else begin
            exp_r = expected_faces.pop_front();
            check_field("face_mask", exp_r.face_mask, rsp_face_mask);
            check_field("top_tile", exp_r.top_tile, rsp_top_tile);
            check_field("side_tile", exp_r.side_tile, rsp_side_tile);
            check_field("bad_block", exp_r.bad_block, rsp_bad_block);
            beats_checked++;
         end
      end
   end

   initial begin : receiver
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         // one long hold-off so the block backs up into its input
         if (!hold_done && beats_checked >= 150) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 26);
         end
      end
   end

   initial begin : stimulus
      int bx, by, bz;
      bx = 0;
      by = 0;
      bz = 0;
      foreach (chunk_model[i]) chunk_model[i] = KIND_AIR;

      // empty chunk, corners, every kind alone, then a few neighbors
      directed_ops.push_back(query_typed(0, 0, 0, 6'd0, 3'd0, 3'd0, 1'b0));
      directed_ops.push_back(query_typed(15, 63, 15, 6'd0, 3'd0, 3'd0, 1'b0));
      directed_ops.push_back(op(CMD_WRITE, 0, 0, 0, KIND_GRASS));
      directed_ops.push_back(query_typed(0, 0, 0, ALL_FACES, 3'd0, 3'd1, 1'b0));
      directed_ops.push_back(op(CMD_WRITE, 15, 63, 15, KIND_OTHER));
      directed_ops.push_back(query_typed(15, 63, 15, ALL_FACES, 3'd0, 3'd0, 1'b1));
      directed_ops.push_back(op(CMD_WRITE, 4, 10, 4, KIND_DIRT));
      directed_ops.push_back(query_typed(4, 10, 4, ALL_FACES, 3'd2, 3'd2, 1'b0));
      directed_ops.push_back(op(CMD_WRITE, 8, 20, 8, KIND_STONE));
      directed_ops.push_back(query_typed(8, 20, 8, ALL_FACES, 3'd3, 3'd3, 1'b0));
      directed_ops.push_back(op(CMD_WRITE, 12, 30, 4, KIND_SAND));
      directed_ops.push_back(query_typed(12, 30, 4, ALL_FACES, 3'd7, 3'd7, 1'b0));
      directed_ops.push_back(op(CMD_WRITE, 4, 40, 12, KIND_WOOD));
      directed_ops.push_back(query_typed(4, 40, 12, ALL_FACES, 3'd5, 3'd4, 1'b0));
      directed_ops.push_back(op(CMD_WRITE, 8, 50, 12, KIND_LEAVES));
      directed_ops.push_back(query_typed(8, 50, 12, ALL_FACES, 3'd6, 3'd6, 1'b0));
      directed_ops.push_back(op(CMD_WRITE, 1, 0, 0, KIND_STONE));
      directed_ops.push_back(op(CMD_WRITE, 0, 1, 0, KIND_DIRT));
      directed_ops.push_back(op(CMD_WRITE, 0, 0, 1, KIND_SAND));
      directed_ops.push_back(op(CMD_QUERY, 0, 0, 0, KIND_AIR));
      directed_ops.push_back(op(CMD_WRITE, 0, 1, 0, KIND_AIR));
      directed_ops.push_back(op(CMD_QUERY, 0, 0, 0, KIND_AIR));
      directed_ops.push_back(op(CMD_QUERY, 1, 0, 0, KIND_AIR));
      directed_ops.push_back(query_typed(2, 0, 0, 6'd0, 3'd0, 3'd0, 1'b0));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_ops[i]) send_op(directed_ops[i]);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // move the working cluster now and then, often onto a chunk face
         if (n % CLUSTER_ITEMS == 0) begin
            case ($urandom_range(2))
               0: bx = 0;
               1: bx = CHUNK_WIDTH - 4;
               default: bx = $urandom_range(CHUNK_WIDTH - 4);
            endcase
            case ($urandom_range(2))
               0: by = 0;
               1: by = CHUNK_HEIGHT - 4;
               default: by = $urandom_range(CHUNK_HEIGHT - 4);
            endcase
            case ($urandom_range(2))
               0: bz = 0;
               1: bz = CHUNK_WIDTH - 4;
               default: bz = $urandom_range(CHUNK_WIDTH - 4);
            endcase
         end
         calm <= (n >= 600 && n < 900);
         send_op(random_op(bx, by, bz, n % CLUSTER_ITEMS));
      end
      req_valid <= 1'b0;

      while (expected_faces.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("accepted %0d writes and %0d queries, %0d result beats checked",
               write_count, query_count, beats_checked);
      $display("%0d queries hit solid voxels, %0d faces found hidden by neighbors",
               solid_queries, hidden_faces);
      if (mismatch_count == 0)
         $display("tb_voxel_face_visibility: clean");
      else
         $display("tb_voxel_face_visibility: errors");
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("%0t: timeout", $time);
      $display("tb_voxel_face_visibility: errors");
      $finish;
   end

endmodule
